FILE: rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// shared request and response types and codes for the scheduler tick engine
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] MODE_FCFS     = 3'd0;
  localparam logic [2:0] MODE_RR       = 3'd1;
  localparam logic [2:0] MODE_SRTF     = 3'd2;
  localparam logic [2:0] MODE_SJF      = 3'd3;
  localparam logic [2:0] MODE_PRIO     = 3'd4;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_SLICE     = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  proc_id;
    logic [7:0]  burst_len;
    logic [15:0] arrive_time;
    logic [7:0]  prio_level;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [5:0]  running_id;
    logic        idle;
    logic        all_done;
    logic [15:0] tick_time;
  } rsp_t;

endpackage

FILE: rtl/cst_min_scan.sv
// ----------------------------------------------------------------------------
// cst_min_scan
// running minimum over table entries streamed one per cycle
// ----------------------------------------------------------------------------
module cst_min_scan #(
  parameter int SLOT_BITS = 5,
  parameter int KEY_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 sample,
  input  logic [SLOT_BITS-1:0] cand_slot,
  input  logic [KEY_BITS-1:0]  cand_key,
  input  logic                 cand_started,
  input  logic                 cand_live,
  output logic                 best_valid,
  output logic [SLOT_BITS-1:0] best_slot
);

  logic [KEY_BITS-1:0] best_key;
  logic                best_started;
  logic                better;

  assign better = !best_valid || (cand_key < best_key) ||
                  ((cand_key == best_key) && !cand_started && best_started);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (clear) begin
      best_valid <= 1'b0;
    end else if (sample && cand_live && better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sample && cand_live && better) begin
      best_key     <= cand_key;
      best_started <= cand_started;
      best_slot    <= cand_slot;
    end
  end

endmodule

FILE: rtl/cpu_scheduler_tick_engine_top.sv
// ----------------------------------------------------------------------------
// cpu_scheduler_tick_engine_top
// tick-driven cpu scheduler with fcfs, round robin, srtf, sjf and priority
// ----------------------------------------------------------------------------
// A load request passes through the done state and back to idle. A tick
// request admits arrived processes from the table and ends there if all
// work is done. Otherwise, in the minimum-search modes it makes one pass
// over the admitted part of the process table (one entry read per cycle;
// sjf skips the pass while its last process still runs), or in the queue
// modes it skips finished queue heads; it then runs or idles one time step
// and makes a second admit pass. Each admit pass stops at a process not
// yet arrived. The process table memory has a single read port. A response
// that waits for the receiver holds off the next request.
module cpu_scheduler_tick_engine_top #(
  parameter int MAX_PROCS  = 32,
  parameter int BURST_BITS = 8,
  parameter int TIME_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cst_pkg::req_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output cst_pkg::rsp_t out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int KW = (BURST_BITS > 8) ? BURST_BITS : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADM   = 4'd1;
  localparam logic [3:0] S_ADMW  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_FQ    = 4'd4;
  localparam logic [3:0] S_FQW   = 4'd5;
  localparam logic [3:0] S_FTW   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_RUN   = 4'd9;
  localparam logic [3:0] S_NORUN = 4'd10;
  localparam logic [3:0] S_PUSH  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  typedef struct packed {
    logic [5:0]            id;
    logic [BURST_BITS-1:0] rem;
    logic [TIME_BITS-1:0]  arr;
    logic [7:0]            prio;
    logic                  started;
  } entry_t;

  entry_t tbl_mem [MAX_PROCS];
  entry_t tbl_rd;
  entry_t tbl_wd;
  logic   tbl_re, tbl_we;
  logic [SW-1:0] tbl_ra, tbl_wa;

  logic [SW-1:0] q_mem [MAX_PROCS];
  logic [SW-1:0] q_rd;
  logic          q_re, q_we;
  logic [SW-1:0] q_ra, q_wa, q_wd;

  logic [3:0]           state;
  logic                 phase;
  logic [2:0]           sched_mode;
  logic [7:0]           time_slice;
  logic [SW-1:0]        head;
  logic [CW-1:0]        count;
  logic [CW-1:0]        loaded_count;
  logic [CW-1:0]        live_count;
  logic [CW-1:0]        admit_ptr;
  logic [TIME_BITS-1:0] time_now;
  logic [7:0]           slice_used;
  logic                 run_valid;
  logic [SW-1:0]        run_slot;
  logic [SW-1:0]        slot;
  logic                 rotate;
  logic [CW-1:0]        scan_idx;
  logic                 pend;
  logic [SW-1:0]        pend_idx;
  cst_pkg::rsp_t        res;

  logic                 fifo, by_prio, adm_more, scan_more, adm_push;
  logic [SW:0]          tail_sum;
  logic [SW-1:0]        tail, head_inc;
  logic [BURST_BITS-1:0] rem_dec;
  logic [7:0]           slice_inc, lim;
  logic                 best_valid, scan_clear;
  logic [SW-1:0]        best_slot;
  logic [KW-1:0]        cand_key;
  logic                 accept_in;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept_in = in_valid && in_ready;

  assign fifo = (sched_mode == cst_pkg::MODE_FCFS) || (sched_mode == cst_pkg::MODE_RR) ||
                (sched_mode > cst_pkg::MODE_PRIO);
  assign by_prio   = (sched_mode == cst_pkg::MODE_PRIO);
  assign adm_more  = (admit_ptr < loaded_count);
  assign scan_more = (scan_idx < admit_ptr);
  assign adm_push  = (tbl_rd.arr <= time_now) && (tbl_rd.rem != '0) &&
                     (count < CW'(MAX_PROCS));
  assign tail_sum  = (SW+1)'(head) + (SW+1)'(count);
  assign tail      = (tail_sum >= (SW+1)'(MAX_PROCS)) ?
                     SW'(tail_sum - (SW+1)'(MAX_PROCS)) : SW'(tail_sum);
  assign head_inc  = (head == SW'(MAX_PROCS - 1)) ? '0 : head + 1'b1;
  assign rem_dec   = tbl_rd.rem - 1'b1;
  assign slice_inc = (slice_used < 8'd255) ? slice_used + 8'd1 : slice_used;
  assign lim       = (time_slice == 8'd0) ? 8'd1 : time_slice;
  assign cand_key  = by_prio ? KW'(tbl_rd.prio) : KW'(tbl_rd.rem);
  assign scan_clear = (state == S_CHK);

  cst_min_scan #(
    .SLOT_BITS (SW),
    .KEY_BITS  (KW)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (scan_clear),
    .sample       (pend),
    .cand_slot    (pend_idx),
    .cand_key     (cand_key),
    .cand_started (tbl_rd.started),
    .cand_live    (tbl_rd.rem != '0),
    .best_valid   (best_valid),
    .best_slot    (best_slot)
  );

  // memory port selection
  always_comb begin
    tbl_re = 1'b0;
    tbl_ra = admit_ptr[SW-1:0];
    tbl_we = 1'b0;
    tbl_wa = slot;
    tbl_wd = tbl_rd;
    q_re   = 1'b0;
    q_ra   = head;
    q_we   = 1'b0;
    q_wa   = tail;
    q_wd   = slot;
    case (state)
      S_IDLE: begin
        tbl_we = accept_in && (in_data.kind == cst_pkg::KIND_LOAD) &&
                 (loaded_count < CW'(MAX_PROCS));
        tbl_wa = loaded_count[SW-1:0];
        tbl_wd.id      = in_data.proc_id;
        tbl_wd.rem     = BURST_BITS'(in_data.burst_len);
        tbl_wd.arr     = TIME_BITS'(in_data.arrive_time);
        tbl_wd.prio    = in_data.prio_level;
        tbl_wd.started = 1'b0;
      end
      S_ADM: begin
        tbl_re = adm_more;
      end
      S_ADMW: begin
        q_we = adm_push;
        q_wd = admit_ptr[SW-1:0];
      end
      S_FQ: begin
        q_re = (count != '0);
      end
      S_FQW: begin
        tbl_re = 1'b1;
        tbl_ra = q_rd;
      end
      S_SCAN: begin
        tbl_re = scan_more;
        tbl_ra = scan_idx[SW-1:0];
      end
      S_RD: begin
        tbl_re = 1'b1;
        tbl_ra = slot;
      end
      S_RUN: begin
        tbl_we = 1'b1;
        tbl_wd.rem     = rem_dec;
        tbl_wd.started = 1'b1;
      end
      S_PUSH: begin
        q_we = rotate && (count < CW'(MAX_PROCS));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_rd <= q_mem[q_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= cst_pkg::MODE_FCFS;
      time_slice <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cst_pkg::CFG_MODE) begin
        sched_mode <= cfg_data[2:0];
      end else if (cfg_index == cst_pkg::CFG_SLICE) begin
        time_slice <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= 1'b0;
      head         <= '0;
      count        <= '0;
      loaded_count <= '0;
      live_count   <= '0;
      admit_ptr    <= '0;
      time_now     <= '0;
      slice_used   <= '0;
      run_valid    <= 1'b0;
      rotate       <= 1'b0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            res.accepted   <= (in_data.kind == cst_pkg::KIND_TICK) ||
                              (loaded_count < CW'(MAX_PROCS));
            res.running_id <= '0;
            res.idle       <= 1'b0;
            res.all_done   <= 1'b0;
            res.tick_time  <= '0;
            phase     <= 1'b0;
            rotate    <= 1'b0;
            if (in_data.kind == cst_pkg::KIND_LOAD) begin
              state <= S_DONE;
              if (loaded_count < CW'(MAX_PROCS)) begin
                if (loaded_count == '0) begin
                  time_now <= TIME_BITS'(in_data.arrive_time);
                end
                loaded_count <= loaded_count + 1'b1;
                if (BURST_BITS'(in_data.burst_len) != '0) begin
                  live_count <= live_count + 1'b1;
                end
              end
            end else begin
              state <= S_ADM;
            end
          end
        end
        S_ADM: begin
          if (adm_more) begin
            state <= S_ADMW;
          end else begin
            state <= phase ? S_PUSH : S_CHK;
          end
        end
        S_ADMW: begin
          if (tbl_rd.arr <= time_now) begin
            admit_ptr <= admit_ptr + 1'b1;
            if (adm_push) begin
              count <= count + 1'b1;
            end
            state <= S_ADM;
          end else begin
            state <= phase ? S_PUSH : S_CHK;
          end
        end
        S_CHK: begin
          scan_idx <= '0;
          pend     <= 1'b0;
          if (live_count == '0) begin
            res.all_done  <= 1'b1;
            res.tick_time <= 16'(time_now);
            state         <= S_DONE;
          end else if (fifo) begin
            state <= S_FQ;
          end else if ((sched_mode == cst_pkg::MODE_SJF) && run_valid) begin
            slot  <= run_slot;
            state <= S_RD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_FQ: begin
          state <= (count != '0) ? S_FQW : S_NORUN;
        end
        S_FQW: begin
          slot  <= q_rd;
          state <= S_FTW;
        end
        S_FTW: begin
          if (tbl_rd.rem == '0) begin
            head       <= head_inc;
            count      <= count - 1'b1;
            slice_used <= '0;
            state      <= S_FQ;
          end else begin
            state <= S_RUN;
          end
        end
        S_SCAN: begin
          pend     <= scan_more;
          pend_idx <= scan_idx[SW-1:0];
          if (scan_more) begin
            scan_idx <= scan_idx + 1'b1;
          end else if (!pend) begin
            if (best_valid) begin
              slot  <= best_slot;
              state <= S_RD;
            end else begin
              state <= S_NORUN;
            end
          end
        end
        S_RD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          res.running_id <= tbl_rd.id;
          res.tick_time  <= 16'(time_now);
          run_valid      <= (rem_dec != '0);
          run_slot       <= slot;
          if (rem_dec == '0) begin
            live_count <= live_count - 1'b1;
          end
          if (fifo) begin
            if (rem_dec == '0) begin
              head       <= head_inc;
              count      <= count - 1'b1;
              slice_used <= '0;
            end else if ((sched_mode == cst_pkg::MODE_RR) && (slice_inc >= lim)) begin
              head       <= head_inc;
              count      <= count - 1'b1;
              slice_used <= '0;
              rotate     <= 1'b1;
            end else begin
              slice_used <= slice_inc;
            end
          end
          time_now <= time_now + 1'b1;
          phase    <= 1'b1;
          state    <= S_ADM;
        end
        S_NORUN: begin
          res.idle      <= 1'b1;
          res.tick_time <= 16'(time_now);
          run_valid     <= 1'b0;
          time_now      <= time_now + 1'b1;
          phase         <= 1'b1;
          state         <= S_ADM;
        end
        S_PUSH: begin
          if (q_we) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PROCS)) else $error("ready queue overflow");
  a_admit_bound: assert property (@(posedge clk) disable iff (rst)
    admit_ptr <= loaded_count) else $error("admit pointer past loaded count");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= loaded_count) else $error("live count past loaded count");
  a_run_live: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> tbl_rd.rem != '0) else $error("picked a finished process");
`endif

endmodule
